// ===== rtl/core/pqme_pkg.sv =====
// Shared types and constants of the min-extract priority queue.
// No dependencies; every other file of the block uses this package.
package pqme_pkg;

    localparam int unsigned PRIO_W = 16;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned OCC_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // One held entry
    typedef struct packed {
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] payload;
    } t_entry;

    // What one cell hands on: the flag to its right-hand neighbor, the entry both ways
    typedef struct packed {
        logic   ahead;    // the new entry sorts ahead of this cell's entry
        t_entry entry;
    } t_link;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ===== rtl/core/pqme_if.sv =====
// Valid/ready channel interfaces of the min-extract priority queue.
// Depends on pqme_pkg for the operation and status codes.
interface pqme_req_if;
    logic                              valid;
    logic                              ready;
    pqme_pkg::t_op                     operation;
    logic [pqme_pkg::PRIO_W-1:0]       priority_req;
    logic signed [pqme_pkg::DATA_W-1:0] payload;

    modport source (output valid, operation, priority_req, payload, input ready);
    modport sink   (input valid, operation, priority_req, payload, output ready);
endinterface

interface pqme_rsp_if;
    logic                              valid;
    logic                              ready;
    pqme_pkg::t_status                 status;
    logic [pqme_pkg::PRIO_W-1:0]       out_priority;
    logic signed [pqme_pkg::DATA_W-1:0] out_payload;
    logic [pqme_pkg::OCC_W-1:0]        occupancy;

    modport source (output valid, status, out_priority, out_payload, occupancy,
                    input ready);
    modport sink   (input valid, status, out_priority, out_payload, occupancy,
                    output ready);
endinterface

// ===== rtl/core/pqme_cell.sv =====
// One slot of the sorted compare-and-shift chain.
// Depends on pqme_pkg for the entry, link and command types.
module pqme_cell (
    input  logic                i_clk,
    input  pqme_pkg::t_cell_ctl i_ctl,
    input  logic                i_occupied,
    input  pqme_pkg::t_entry    i_new,
    input  pqme_pkg::t_link     i_left,
    input  pqme_pkg::t_entry    i_right,
    output pqme_pkg::t_link     o_link
);

    pqme_pkg::t_entry r_entry;
    pqme_pkg::t_entry n_entry;
    logic             w_before;

    // A free slot sorts after everything; equal priorities keep arrival order
    assign w_before = !i_occupied || (i_new.prio < r_entry.prio);

    // Shift left on remove, shift right or take the new entry on insert
    always_comb begin
        priority if (i_ctl.rem) begin
            n_entry = i_right;
        end else if (i_ctl.ins && w_before) begin
            n_entry = i_left.ahead ? i_left.entry : i_new;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.ahead = w_before;
    assign o_link.entry = r_entry;

endmodule

// ===== rtl/core/priority_queue_min_extract_core.sv =====
// Bounded priority queue with extract-min: insert adds an entry, remove
// returns the smallest priority (earliest arrival among equals). Depends on
// pqme_pkg, the channel interfaces and pqme_cell.
//
// Entries are held in a row of QUEUE_DEPTH cells kept sorted by priority, ties
// in arrival order, so the smallest entry always sits in the first cell. An
// insert is placed by every cell comparing it against its own entry and
// shifting right in the same cycle; a remove takes the first cell and shifts
// the row left. Each item's placement rests on one 16-bit compare in each cell,
// and a result is registered in the cycle after its item is accepted. The input
// is accepted while the result register is empty or being drained, so items flow
// at one per cycle when the sink keeps up. Inserting into a full queue reports
// full and drops the entry; removing from an empty queue reports empty. Every
// result carries the occupancy after the operation.
module priority_queue_min_extract_core #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pqme_req_if.sink    i_req,
    pqme_rsp_if.source  o_rsp
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    pqme_pkg::t_cell_ctl w_ctl;
    pqme_pkg::t_entry    w_new;
    pqme_pkg::t_link     w_link [QUEUE_DEPTH];

    logic                              r_out_valid;
    pqme_pkg::t_status                 r_status;
    logic [pqme_pkg::PRIO_W-1:0]       r_prio;
    logic signed [pqme_pkg::DATA_W-1:0] r_payload;
    logic [pqme_pkg::OCC_W-1:0]        r_occ;
    pqme_pkg::t_status                 n_status;
    logic [pqme_pkg::PRIO_W-1:0]       n_prio;
    logic signed [pqme_pkg::DATA_W-1:0] n_payload;
    logic [CNT_W-1:0]                  n_occ;

    // Accept while the result register is free or being taken
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);

    assign w_ctl.ins = w_accept && (i_req.operation == pqme_pkg::OP_INSERT) && !w_full;
    assign w_ctl.rem = w_accept && (i_req.operation == pqme_pkg::OP_REMOVE) && !w_empty;

    assign w_new.prio    = i_req.priority_req;
    assign w_new.payload = i_req.payload;

    // Build the chain of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        pqme_pkg::t_link  w_left;
        pqme_pkg::t_entry w_right;
        logic             w_occupied;

        assign w_occupied = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_left.ahead = 1'b0;
            assign w_left.entry = w_new;
        end else begin : g_body
            assign w_left = w_link[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_link[g+1].entry;
        end

        pqme_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (w_occupied),
            .i_new      (w_new),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_link     (w_link[g])
        );
    end

    // Advance the entry count
    always_comb begin
        priority if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    // Form the result of the accepted item
    always_comb begin
        n_prio    = '0;
        n_payload = '0;
        n_occ     = n_count;
        unique case (i_req.operation)
            pqme_pkg::OP_INSERT: begin
                n_status = w_full ? pqme_pkg::ST_FULL : pqme_pkg::ST_INSERTED;
            end
            pqme_pkg::OP_REMOVE: begin
                if (w_empty) begin
                    n_status = pqme_pkg::ST_EMPTY;
                end else begin
                    n_status  = pqme_pkg::ST_REMOVED;
                    n_prio    = w_link[0].entry.prio;
                    n_payload = w_link[0].entry.payload;
                end
            end
            default: begin
                n_status = pqme_pkg::ST_EMPTY;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_prio    <= n_prio;
            r_payload <= n_payload;
            r_occ     <= pqme_pkg::OCC_W'(n_occ);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.out_priority = r_prio;
    assign o_rsp.out_payload  = r_payload;
    assign o_rsp.occupancy    = r_occ;

    // Count never exceeds the number of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // First two held entries stay in priority order
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_link[0].entry.prio <= w_link[1].entry.prio))
        else $error("cell chain out of order at the head");

    // A remove from a nonempty queue reports removal and drops the count by one
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem |=> (r_status == pqme_pkg::ST_REMOVED)
                      && (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not shrink the queue");

    // A dropped insert leaves the count alone
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.operation == pqme_pkg::OP_INSERT) && w_full)
            |=> (r_status == pqme_pkg::ST_FULL) && $stable(r_count))
        else $error("insert into full queue changed the count");

endmodule

// ===== sim/pqme_extract_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the min-extract priority queue: watches both channels,
// predicts every result from an arrival-order copy of the queue and compares.
// Depends on pqme_pkg and the channel interfaces in pqme_if.
module pqme_extract_checker #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pqme_req_if  i_req,
    pqme_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        pqme_pkg::t_status                  status;
        logic [pqme_pkg::PRIO_W-1:0]        prio;
        logic signed [pqme_pkg::DATA_W-1:0] payload;
        logic [pqme_pkg::OCC_W-1:0]         occupancy;
    } t_result;

    // Entries held in arrival order, oldest in slot 0
    logic [pqme_pkg::PRIO_W-1:0]        held_prio    [QUEUE_DEPTH];
    logic signed [pqme_pkg::DATA_W-1:0] held_payload [QUEUE_DEPTH];
    int unsigned                        held_count;

    t_result pending_results[$];

    // Apply one item to the held entries and return the result it causes
    function automatic t_result predict_step(
        input pqme_pkg::t_op                      op,
        input logic [pqme_pkg::PRIO_W-1:0]        prio,
        input logic signed [pqme_pkg::DATA_W-1:0] data
    );
        t_result     res;
        int unsigned best;
        res = '0;
        if (op == pqme_pkg::OP_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = pqme_pkg::ST_FULL;
            end else begin
                held_prio[held_count]    = prio;
                held_payload[held_count] = data;
                held_count++;
                res.status = pqme_pkg::ST_INSERTED;
            end
        end else if (held_count == 0) begin
            res.status = pqme_pkg::ST_EMPTY;
        end else begin
            // strict compare keeps the earliest arrival among equal priorities
            best = 0;
            for (int unsigned i = 1; i < held_count; i++) begin
                if (held_prio[i] < held_prio[best]) best = i;
            end
            res.status  = pqme_pkg::ST_REMOVED;
            res.prio    = held_prio[best];
            res.payload = held_payload[best];
            // close the gap behind the removed entry
            for (int unsigned i = best + 1; i < held_count; i++) begin
                held_prio[i-1]    = held_prio[i];
                held_payload[i-1] = held_payload[i];
            end
            held_count--;
        end
        res.occupancy = pqme_pkg::OCC_W'(held_count);
        return res;
    endfunction

    task automatic check_field(input string name,
                               input logic [pqme_pkg::DATA_W-1:0] want,
                               input logic [pqme_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // Compare the result leaving the block, then predict the item entering it
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            held_count   = 0;
            o_fail_count = 0;
            pending_results.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    $display({"%0t: result with nothing expected: status %0d, ",
                              "priority 0x%0h, payload 0x%0h, occupancy %0d"},
                             $time, i_rsp.status, i_rsp.out_priority,
                             i_rsp.out_payload, i_rsp.occupancy);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", pqme_pkg::DATA_W'(want.status),
                                pqme_pkg::DATA_W'(i_rsp.status));
                    check_field("out_priority", pqme_pkg::DATA_W'(want.prio),
                                pqme_pkg::DATA_W'(i_rsp.out_priority));
                    check_field("out_payload", want.payload, i_rsp.out_payload);
                    check_field("occupancy", pqme_pkg::DATA_W'(want.occupancy),
                                pqme_pkg::DATA_W'(i_rsp.occupancy));
                end
            end
            if (i_req.valid && i_req.ready) begin
                pending_results.push_back(predict_step(i_req.operation,
                                                       i_req.priority_req,
                                                       i_req.payload));
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== sim/tb_priority_queue_min_extract_core.sv =====
`timescale 1ns / 100ps
// Top of the min-extract priority queue testbench: clock, reset, item traffic,
// receiver stalls, watchdog and verdict. Depends on pqme_pkg, pqme_if,
// the queue core and pqme_extract_checker.
module tb_priority_queue_min_extract_core;

    localparam int unsigned QUEUE_DEPTH      = 16;
    localparam int unsigned RESET_CYCLES     = 9;
    localparam int unsigned RANDOM_ITEMS     = 800;
    localparam int unsigned LONG_HOLD_CYCLES = 250;
    localparam int unsigned IDLE_LIMIT       = 2000;
    localparam int unsigned DRAIN_CYCLES     = 8;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic quiet     = 1'b0;   // no gaps on either side while set
    logic long_hold = 1'b0;   // asks the receiver for one long hold-off
    int   fail_count;
    int   pending;

    pqme_req_if req_bus ();
    pqme_rsp_if rsp_bus ();

    priority_queue_min_extract_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    pqme_extract_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item, hold it until accepted, then idle for a random gap
    task automatic send_item(input pqme_pkg::t_op                      op,
                             input logic [pqme_pkg::PRIO_W-1:0]        prio,
                             input logic signed [pqme_pkg::DATA_W-1:0] data);
        int unsigned gap;
        @(negedge i_clk);
        req_bus.valid        = 1'b1;
        req_bus.operation    = op;
        req_bus.priority_req = prio;
        req_bus.payload      = data;
        do @(posedge i_clk); while (!req_bus.ready);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off when asked
    initial begin : receiver
        int unsigned stall_left;
        stall_left    = 0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                rsp_bus.ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (stall_left > 0) begin
                rsp_bus.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_bus.ready = 1'b1;
                stall_left    = pick_gap();
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        @(posedge i_rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("** priority_queue_min_extract_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int unsigned                        random_sent;
        int unsigned                        burst;
        int unsigned                        burst_len;
        int unsigned                        insert_pct;
        int unsigned                        prio_mode;
        int unsigned                        roll;
        pqme_pkg::t_op                      op;
        logic [pqme_pkg::PRIO_W-1:0]        prio;
        logic signed [pqme_pkg::DATA_W-1:0] data;

        req_bus.valid        = 1'b0;
        req_bus.operation    = pqme_pkg::OP_INSERT;
        req_bus.priority_req = '0;
        req_bus.payload      = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: remove from empty, field extremes, equal priorities, drain
        send_item(pqme_pkg::OP_REMOVE, 16'hFFFF, 32'sh7FFFFFFF);
        send_item(pqme_pkg::OP_INSERT, 16'hFFFF, 32'sh7FFFFFFF);
        send_item(pqme_pkg::OP_INSERT, 16'h0000, 32'sh80000000);
        send_item(pqme_pkg::OP_INSERT, 16'h8000, 32'sh00000000);
        send_item(pqme_pkg::OP_INSERT, 16'h0000, 32'shFFFFFFFF);
        send_item(pqme_pkg::OP_INSERT, 16'h8000, 32'sh5555AAAA);
        send_item(pqme_pkg::OP_INSERT, 16'h7FFF, 32'shAAAA5555);
        repeat (6) send_item(pqme_pkg::OP_REMOVE, 16'h0000, 32'sh00000000);
        send_item(pqme_pkg::OP_REMOVE, 16'h0000, 32'sh00000000);

        // Random bursts with a varying insert/remove mix to reach full and empty
        random_sent = 0;
        burst       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            // Withdraw the offer and wait for every expected result
            if (burst % 8 == 7) begin
                @(negedge i_clk);
                req_bus.valid = 1'b0;
                wait (pending == 0);
            end
            burst_len  = $urandom_range(10, 60);
            insert_pct = 10 + 20 * $urandom_range(0, 4);
            prio_mode  = $urandom_range(0, 2);
            quiet      = ($urandom_range(0, 5) == 0);
            if (burst == 2 || burst == 9) begin
                long_hold = 1'b1;
            end
            repeat (burst_len) begin
                op = ($urandom_range(0, 99) < insert_pct) ? pqme_pkg::OP_INSERT
                                                          : pqme_pkg::OP_REMOVE;
                case (prio_mode)
                    0: prio = pqme_pkg::PRIO_W'($urandom_range(0, 65535));
                    1: prio = pqme_pkg::PRIO_W'($urandom_range(0, 7));
                    default: begin
                        roll = $urandom_range(0, 3);
                        prio = (roll == 0) ? 16'h0000 :
                               (roll == 1) ? 16'hFFFF :
                               pqme_pkg::PRIO_W'($urandom_range(0, 65535));
                    end
                endcase
                roll = $urandom_range(0, 9);
                case (roll)
                    0:       data = 32'sh80000000;
                    1:       data = 32'sh7FFFFFFF;
                    2:       data = 32'sh00000000;
                    3:       data = 32'shFFFFFFFF;
                    default: data = $urandom;
                endcase
                send_item(op, prio, data);
                random_sent++;
            end
            burst++;
        end

        // Drop valid, wait for the last results, then let the pipeline settle
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        quiet         = 1'b1;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("** priority_queue_min_extract_core: PASSED **");
        else
            $display("** priority_queue_min_extract_core: FAILED **");
        $finish;
    end

endmodule
